// File: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Request and response payloads, control codes of the microcode sequencer
// and the microcode program itself.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Character constants
  localparam logic [7:0] ATTR_BYTE  = 8'h0F;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] LINE_FEED  = 8'h0A;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Program step addresses
  localparam step_t ST_FETCH    = 4'd0;
  localparam step_t ST_DEC_CLR  = 4'd1;
  localparam step_t ST_DEC_RD   = 4'd2;
  localparam step_t ST_DEC_PUT  = 4'd3;
  localparam step_t ST_CHK_LF   = 4'd4;
  localparam step_t ST_WRITE    = 4'd5;
  localparam step_t ST_NEWLINE  = 4'd6;
  localparam step_t ST_COPY     = 4'd7;
  localparam step_t ST_DRAIN    = 4'd8;
  localparam step_t ST_BLANK    = 4'd9;
  localparam step_t ST_TO_DONE  = 4'd10;
  localparam step_t ST_CLEAR    = 4'd11;
  localparam step_t ST_HOME     = 4'd12;
  localparam step_t ST_RD_ISSUE = 4'd13;
  localparam step_t ST_RD_CAP   = 4'd14;
  localparam step_t ST_DONE     = 4'd15;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } req_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
  } rsp_t;

  // Datapath actions
  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,
    A_INIT,
    A_WR_CHAR,
    A_NEWLINE,
    A_COPY,
    A_FILL,
    A_HOME,
    A_RD_ISSUE,
    A_RD_CAP,
    A_RESULT
  } act_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_IS_CLEAR,
    C_IS_READ,
    C_NOT_PUT,
    C_IS_LF,
    C_COL_NOT_LAST,
    C_ROW_NOT_LAST,
    C_COPY_MORE,
    C_FILL_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } uword_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic accept;
    logic is_clear;
    logic is_read;
    logic not_put;
    logic is_lf;
    logic col_last;
    logic row_last;
    logic copy_more;
    logic fill_more;
    logic out_busy;
  } status_t;

  // Microcode program
  function automatic uword_t tcw_ucode(input step_t step);
    uword_t w;
    case (step)
      ST_FETCH:    w = '{A_LOAD,     C_NO_ACCEPT,    ST_FETCH};
      ST_DEC_CLR:  w = '{A_INIT,     C_IS_CLEAR,     ST_CLEAR};
      ST_DEC_RD:   w = '{A_NONE,     C_IS_READ,      ST_RD_ISSUE};
      ST_DEC_PUT:  w = '{A_NONE,     C_NOT_PUT,      ST_DONE};
      ST_CHK_LF:   w = '{A_NONE,     C_IS_LF,        ST_NEWLINE};
      ST_WRITE:    w = '{A_WR_CHAR,  C_COL_NOT_LAST, ST_DONE};
      ST_NEWLINE:  w = '{A_NEWLINE,  C_ROW_NOT_LAST, ST_DONE};
      ST_COPY:     w = '{A_COPY,     C_COPY_MORE,    ST_COPY};
      ST_DRAIN:    w = '{A_NONE,     C_NEVER,        ST_FETCH};
      ST_BLANK:    w = '{A_FILL,     C_FILL_MORE,    ST_BLANK};
      ST_TO_DONE:  w = '{A_NONE,     C_ALWAYS,       ST_DONE};
      ST_CLEAR:    w = '{A_FILL,     C_FILL_MORE,    ST_CLEAR};
      ST_HOME:     w = '{A_HOME,     C_ALWAYS,       ST_DONE};
      ST_RD_ISSUE: w = '{A_RD_ISSUE, C_NEVER,        ST_FETCH};
      ST_RD_CAP:   w = '{A_RD_CAP,   C_ALWAYS,       ST_DONE};
      ST_DONE:     w = '{A_RESULT,   C_OUT_BUSY,     ST_DONE};
      default:     w = '{A_NONE,     C_ALWAYS,       ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

// File: design/tcw_chan_if.sv
// ----------------------------------------------------------------------------
// tcw_chan_if: valid/ready channel
// Carries one payload per request; a transfer happens when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface tcw_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic single-port-write RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/tcw_seq.sv
// ----------------------------------------------------------------------------
// tcw_seq: microcode sequencer
// Step counter over the program table; each step either jumps on its
// condition or falls through to the next step.
// ----------------------------------------------------------------------------
module tcw_seq (
  input  logic             clk,
  input  logic             rst,
  input  tcw_pkg::status_t status,
  output tcw_pkg::act_t    act
);
  import tcw_pkg::*;

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   taken;

  assign uw  = tcw_ucode(pc);
  assign act = uw.act;

  // Evaluate the jump condition of the current step
  always_comb begin
    case (uw.cond)
      C_NEVER:        taken = 1'b0;
      C_ALWAYS:       taken = 1'b1;
      C_NO_ACCEPT:    taken = !status.accept;
      C_IS_CLEAR:     taken = status.is_clear;
      C_IS_READ:      taken = status.is_read;
      C_NOT_PUT:      taken = status.not_put;
      C_IS_LF:        taken = status.is_lf;
      C_COL_NOT_LAST: taken = !status.col_last;
      C_ROW_NOT_LAST: taken = !status.row_last;
      C_COPY_MORE:    taken = status.copy_more;
      C_FILL_MORE:    taken = status.fill_more;
      C_OUT_BUSY:     taken = status.out_busy;
      default:        taken = 1'b0;
    endcase
    pc_next = taken ? uw.target : pc + step_t'(1);
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: design/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath: cursor, sweep pointer and cell store
// Carries out the action of each microcode step and reports the flags
// that the sequencer branches on.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  tcw_pkg::act_t    act,
  output tcw_pkg::status_t status,
  tcw_chan_if.sink         req,
  tcw_chan_if.source       rsp
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = (AW > 11) ? AW : 11;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [1:0]    req_type;
  logic [7:0]    char_code;
  logic [4:0]    read_row;
  logic [6:0]    read_col;
  logic [CW-1:0] cursor_col;
  logic [RW-1:0] cursor_row;
  logic [AW-1:0] ptr;
  logic          wb_valid;
  logic [AW-1:0] wb_addr;
  logic [15:0]   cell_word;
  logic          out_valid;
  rsp_t          out_data;

  logic [PW-1:0] cur_lin;
  logic [PW-1:0] rd_lin;
  logic          in_grid;
  logic          accept;
  logic          out_busy;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  assign cur_lin  = PW'(cursor_row) * PW'(COLUMNS) + PW'(cursor_col);
  assign rd_lin   = PW'(read_row) * PW'(COLUMNS) + PW'(read_col);
  assign in_grid  = ({3'b000, read_row} < 8'(ROWS)) && ({1'b0, read_col} < 8'(COLUMNS));
  assign req.ready = (act == A_LOAD);
  assign accept   = req.valid && req.ready;
  assign out_busy = out_valid && !rsp.ready;

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  // Flags for the sequencer
  always_comb begin
    status.accept    = accept;
    status.is_clear  = (req_type == REQ_CLEAR);
    status.is_read   = (req_type == REQ_READ);
    status.not_put   = (req_type != REQ_PUT);
    status.is_lf     = (char_code == LINE_FEED);
    status.col_last  = (cursor_col == CW'(COLUMNS - 1));
    status.row_last  = (cursor_row == RW'(ROWS - 1));
    status.copy_more = (ptr != AW'(CELLS - COLUMNS - 1));
    status.fill_more = (ptr != AW'(CELLS - 1));
    status.out_busy  = out_busy;
  end

  // Cell store ports; a pending copy write yields to a char write or fill
  always_comb begin
    we    = 1'b0;
    waddr = wb_addr;
    wdata = rdata;
    raddr = rd_lin[AW-1:0];
    if (wb_valid) begin
      we = 1'b1;
    end
    case (act)
      A_WR_CHAR: begin
        we    = 1'b1;
        waddr = cur_lin[AW-1:0];
        wdata = char_code;
      end
      A_FILL: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = BLANK_CHAR;
      end
      A_COPY: begin
        raddr = ptr + AW'(COLUMNS);
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Control state: cursor, copy stage and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      wb_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      wb_valid <= (act == A_COPY);
      case (act)
        A_WR_CHAR: begin
          if (!status.col_last) begin
            cursor_col <= cursor_col + CW'(1);
          end
        end
        A_NEWLINE: begin
          cursor_col <= '0;
          if (!status.row_last) begin
            cursor_row <= cursor_row + RW'(1);
          end
        end
        A_HOME: begin
          cursor_col <= '0;
          cursor_row <= '0;
        end
        default: begin
        end
      endcase
      if (act == A_RESULT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: request fields, sweep pointer, cell and result
  always_ff @(posedge clk) begin
    case (act)
      A_LOAD: begin
        if (accept) begin
          req_type  <= req.payload.req_type;
          char_code <= req.payload.char_code;
          read_row  <= req.payload.read_row;
          read_col  <= req.payload.read_col;
        end
      end
      A_INIT: begin
        ptr       <= '0;
        cell_word <= '0;
      end
      A_COPY: begin
        wb_addr <= ptr;
        ptr     <= ptr + AW'(1);
      end
      A_FILL: begin
        ptr <= ptr + AW'(1);
      end
      A_RD_CAP: begin
        cell_word <= in_grid ? {ATTR_BYTE, rdata} : 16'h0000;
      end
      A_RESULT: begin
        if (!out_busy) begin
          out_data.cursor_pos <= cur_lin[10:0];
          out_data.cell_data  <= cell_word;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console
// Request channel req carries req_type, char_code, read_row and read_col;
// response channel rsp returns cursor_pos and cell_data, one per request.
//
// A microcode program steps one request at a time through a cell RAM of
// ROWS*COLUMNS bytes with a single write port and a separate read port. A
// clear blanks every cell, and a put or line feed that scrolls copies the
// rows up and blanks the last row, one cell copied or blanked per cycle
// through the RAM ports. The next request is accepted in the cycle after
// the response is loaded, while that response still waits in the output
// register. If rsp stalls, the following response holds its last step
// until the register frees. Reset homes the cursor and drops any waiting
// response; cell contents are undefined until a clear or a write, no
// clearing pass runs.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  tcw_chan_if.sink   req,
  tcw_chan_if.source rsp
);
  import tcw_pkg::*;

  act_t    act;
  status_t status;

  tcw_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .act    (act)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .act    (act),
    .status (status),
    .req    (req),
    .rsp    (rsp)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for text_console_writer
// Requests are queued by a stimulus block and driven by a clocked driver. A
// shadow of the console (cells plus cursor) computes the expected response
// for each accepted request, and a clocked monitor compares every response,
// field by field, in order. Sender idling and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int COLS       = 80;
  localparam int NROWS      = 25;
  localparam int CELLS      = COLS * NROWS;
  localparam int HOLD_LEN   = 300;
  localparam int SETTLE_CYC = 40;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic clk;
  logic rst;

  tcw_chan_if #(.payload_t(req_t)) req_ch ();
  tcw_chan_if #(.payload_t(rsp_t)) rsp_ch ();

  text_console_writer #(
    .COLUMNS (COLS),
    .ROWS    (NROWS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Pending requests, expected responses and run bookkeeping
  req_t pending_req[$];
  rsp_t expected_rsp[$];
  int   errors;
  int   queued_count;
  int   snd_idle_pct;
  int   rcv_stall_pct;
  int   hold_req;
  int   hold_done;
  int   hold_left;
  logic req_fire;

  // Shadow of the console
  logic [7:0] shadow_cells [0:CELLS-1];
  int         shadow_col;
  int         shadow_row;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Move to the next line, scrolling on the last row
  function automatic void shadow_newline();
    if (shadow_row >= NROWS - 1) begin
      for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) shadow_cells[i] = BLANK_CHAR;
      shadow_row = NROWS - 1;
    end else begin
      shadow_row++;
    end
    shadow_col = 0;
  endfunction

  // Apply one request to the shadow and form its response
  function automatic rsp_t console_apply(req_t r);
    rsp_t o;
    o.cell_data = '0;
    case (r.req_type)
      REQ_PUT: begin
        if (r.char_code == LINE_FEED) begin
          shadow_newline();
        end else begin
          shadow_cells[shadow_row * COLS + shadow_col] = r.char_code;
          shadow_col++;
          if (shadow_col >= COLS) shadow_newline();
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = BLANK_CHAR;
        shadow_col = 0;
        shadow_row = 0;
      end
      REQ_READ: begin
        if (r.read_row < NROWS && r.read_col < COLS)
          o.cell_data = {ATTR_BYTE, shadow_cells[r.read_row * COLS + r.read_col]};
      end
      default: ;
    endcase
    o.cursor_pos = 11'(shadow_row * COLS + shadow_col);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, exp_val, got_val);
    errors++;
  endtask

  task automatic queue_req(input logic [1:0] kind, input logic [7:0] ch,
                           input logic [4:0] row, input logic [6:0] col);
    req_t item;
    item.req_type  = kind;
    item.char_code = ch;
    item.read_row  = row;
    item.read_col  = col;
    pending_req.push_back(item);
    if (kind != REQ_UNKNOWN) queued_count++;
  endtask

  task automatic queue_read_outside();
    if ($urandom_range(1))
      queue_req(REQ_READ, 8'($urandom), 5'($urandom_range(NROWS, 31)), 7'($urandom_range(127)));
    else
      queue_req(REQ_READ, 8'($urandom), 5'($urandom_range(31)), 7'($urandom_range(COLS, 127)));
  endtask

  // Queue random bursts: text lines, line feed runs, reads, clears, noise
  task automatic gen_random(input int count);
    int target;
    int pick;
    int len;
    target = queued_count + count;
    while (queued_count < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = $urandom_range(1, 95);
        repeat (len) begin
          queue_req(REQ_PUT, ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                      : 8'($urandom_range(32, 126)),
                    5'($urandom), 7'($urandom));
        end
        if ($urandom_range(1)) queue_req(REQ_PUT, LINE_FEED, 5'($urandom), 7'($urandom));
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 28)) queue_req(REQ_PUT, LINE_FEED, 5'($urandom), 7'($urandom));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) begin
          queue_req(REQ_READ, 8'($urandom), 5'($urandom_range(NROWS - 1)),
                    7'($urandom_range(COLS - 1)));
        end
      end else if (pick < 88) begin
        queue_req(REQ_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
      end else if (pick < 93) begin
        queue_req(REQ_UNKNOWN, 8'($urandom), 5'($urandom), 7'($urandom));
      end else if (pick < 97) begin
        queue_req(REQ_PUT, 8'($urandom_range(255)), 5'($urandom), 7'($urandom));
      end else begin
        queue_read_outside();
      end
    end
  endtask

  task automatic wait_drained();
    wait (pending_req.size() == 0 && expected_rsp.size() == 0);
    @(negedge clk);
  endtask

  // Request driver: hold the request until taken, then offer the next one
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (pending_req.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        req_ch.valid   <= 1'b1;
        req_ch.payload <= pending_req[0];
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Accept requests and predict their responses
  always @(posedge clk) begin
    req_fire <= !rst && req_ch.valid && req_ch.ready;
    if (!rst && req_ch.valid && req_ch.ready) begin
      expected_rsp.push_back(console_apply(req_ch.payload));
      void'(pending_req.pop_front());
    end
  end

  // Response ready: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= hold_req;
    end
    rsp_ch.ready <= !rst && hold_left == 0 && hold_req == hold_done &&
                    $urandom_range(99) >= rcv_stall_pct;
  end

  // Response monitor: compare against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected response", 0, int'(rsp_ch.payload));
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_ch.payload.cursor_pos !== want.cursor_pos)
          report_mismatch("cursor_pos", want.cursor_pos, rsp_ch.payload.cursor_pos);
        if (rsp_ch.payload.cell_data !== want.cell_data)
          report_mismatch("cell_data", want.cell_data, rsp_ch.payload.cell_data);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    errors         = 0;
    queued_count   = 0;
    snd_idle_pct   = 0;
    rcv_stall_pct  = 0;
    hold_req       = 0;
    hold_done      = 0;
    hold_left      = 0;
    req_fire       = 1'b0;
    shadow_col     = 0;
    shadow_row     = 0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    rst            = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Before any clear: read back only cells just written
    queue_req(REQ_PUT, 8'h41, 5'd0, 7'd0);
    queue_req(REQ_PUT, 8'h00, 5'd31, 7'd127);
    queue_req(REQ_PUT, 8'hFF, 5'd0, 7'd0);
    queue_req(REQ_PUT, 8'h80, 5'd0, 7'd0);
    queue_req(REQ_READ, 8'h00, 5'd0, 7'd0);
    queue_req(REQ_READ, 8'hFF, 5'd0, 7'd2);
    queue_req(REQ_READ, 8'h00, 5'd0, 7'd3);
    // Reads outside the grid
    queue_req(REQ_READ, 8'h00, 5'(NROWS), 7'd0);
    queue_req(REQ_READ, 8'h00, 5'd31, 7'd127);
    queue_req(REQ_READ, 8'h00, 5'd0, 7'(COLS));
    // Unknown request changes nothing
    queue_req(REQ_UNKNOWN, 8'hFF, 5'd31, 7'd127);
    queue_req(REQ_CLEAR, 8'h00, 5'd0, 7'd0);
    queue_req(REQ_READ, 8'h00, 5'(NROWS - 1), 7'(COLS - 1));
    queue_req(REQ_READ, 8'h00, 5'd0, 7'd0);
    queue_req(REQ_PUT, LINE_FEED, 5'd0, 7'd0);
    queue_req(REQ_PUT, 8'h7F, 5'd0, 7'd0);
    queue_req(REQ_READ, 8'h00, 5'd1, 7'd0);
    queue_req(REQ_PUT, 8'h20, 5'd0, 7'd0);
    queue_req(REQ_PUT, LINE_FEED, 5'd0, 7'd0);
    queue_req(REQ_READ, 8'h00, 5'd1, 7'd1);
    wait_drained();

    // No idling, with one long response hold-off while requests queue up
    gen_random(360);
    hold_req++;
    wait_drained();

    snd_idle_pct  = 78;
    rcv_stall_pct = 0;
    gen_random(360);
    wait_drained();

    snd_idle_pct  = 0;
    rcv_stall_pct = 78;
    gen_random(360);
    wait_drained();

    snd_idle_pct  = 12;
    rcv_stall_pct = 12;
    gen_random(360);
    wait_drained();

    repeat (SETTLE_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
